FILE: sv/qle_pkg.sv
`default_nettype none

package qle_pkg;

   // Table geometry
   localparam int GRID_X_CELLS = 32;
   localparam int GRID_Y_CELLS = 32;
   localparam int HEADING_BINS = 8;
   localparam int NUM_ACTIONS  = 4;

   localparam int X_W     = $clog2(GRID_X_CELLS);
   localparam int Y_W     = $clog2(GRID_Y_CELLS);
   localparam int H_W     = $clog2(HEADING_BINS);
   localparam int ACT_W   = $clog2(NUM_ACTIONS);
   localparam int STATE_W = X_W + Y_W + H_W;
   localparam int ADDR_W  = STATE_W + ACT_W;
   localparam int STORE_DEPTH = GRID_X_CELLS * GRID_Y_CELLS * HEADING_BINS * NUM_ACTIONS;
   localparam int CNT_W   = $clog2(NUM_ACTIONS + 1);

   // Fixed-point formats
   localparam int Q_W    = 32;
   localparam int FRAC_W = 16;

   // Request kinds
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Register map
   localparam logic REG_LEARNING_RATE   = 1'b0;
   localparam logic REG_DISCOUNT_FACTOR = 1'b1;
   localparam logic [FRAC_W-1:0] LEARNING_RATE_RESET   = 16'd6554;
   localparam logic [FRAC_W-1:0] DISCOUNT_FACTOR_RESET = 16'd64881;

   typedef struct packed {
      logic [FRAC_W-1:0] alpha;
      logic [FRAC_W-1:0] gamma;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [Q_W-1:0]    wdata;
   } ram_req_type;

   typedef struct packed {
      logic clearing;
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_GAMMA,
      ST_DIFF,
      ST_ALPHA,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: sv/qle_ram.sv
`default_nettype none

module qle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry when enabled and read one entry, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/qle_csr.sv
`default_nettype none

module qle_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output qle_pkg::cfg_type cfg
);

   qle_pkg::cfg_type cfg_ff;
   qle_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // Decode the write word
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            qle_pkg::REG_LEARNING_RATE:   cfg_in.alpha = pwdata[qle_pkg::FRAC_W-1:0];
            qle_pkg::REG_DISCOUNT_FACTOR: cfg_in.gamma = pwdata[qle_pkg::FRAC_W-1:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha <= qle_pkg::LEARNING_RATE_RESET;
         cfg_ff.gamma <= qle_pkg::DISCOUNT_FACTOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (paddr[2])
         qle_pkg::REG_LEARNING_RATE:   prdata = 32'(cfg_ff.alpha);
         qle_pkg::REG_DISCOUNT_FACTOR: prdata = 32'(cfg_ff.gamma);
         default:                      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: sv/qle_core.sv
`default_nettype none

module qle_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire qle_pkg::cfg_type              cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [qle_pkg::X_W-1:0]       req_cell_x,
   input  wire logic [qle_pkg::Y_W-1:0]       req_cell_y,
   input  wire logic [qle_pkg::H_W-1:0]       req_heading_bin,
   input  wire logic [1:0]                    req_action_index,
   input  wire logic signed [31:0]            req_reward_value,
   input  wire logic [qle_pkg::X_W-1:0]       req_next_cell_x,
   input  wire logic [qle_pkg::Y_W-1:0]       req_next_cell_y,
   input  wire logic [qle_pkg::H_W-1:0]       req_next_heading_bin,
   input  wire logic                          req_episode_done,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_greedy_action,
   output logic signed [31:0]                 rsp_q_result,
   output qle_pkg::ram_req_type               ram_req,
   input  wire logic [qle_pkg::Q_W-1:0]       ram_rdata,
   output qle_pkg::status_type                status
);

   localparam int ACT_W   = qle_pkg::ACT_W;
   localparam int STATE_W = qle_pkg::STATE_W;
   localparam int ADDR_W  = qle_pkg::ADDR_W;
   localparam int CNT_W   = qle_pkg::CNT_W;

   qle_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0]   tag_ff;
   logic               tag_vld_ff;

   // Latched request
   logic               kind_ff;
   logic [STATE_W-1:0] cur_ff, nxt_ff;
   logic [1:0]         act_ff;
   logic signed [31:0] rew_ff;
   logic               done_ff;

   // Datapath registers
   logic signed [31:0] q_ff;
   logic signed [31:0] best_val_ff;
   logic [ACT_W-1:0]   best_act_ff;
   logic signed [48:0] gprod_ff;
   logic signed [34:0] diff_ff;
   logic signed [51:0] aprod_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_act_ff;
   logic signed [31:0] rsp_q_ff;

   logic               accept, last_rd, clr_last, out_free, load;
   logic               data_is_q;
   logic [ACT_W-1:0]   data_act;
   logic [ACT_W-1:0]   rd_act;
   logic signed [31:0] rd_val;
   logic signed [31:0] m_sel;
   logic signed [48:0] gprod_in;
   logic signed [34:0] diff_in;
   logic signed [51:0] aprod_in;
   logic signed [35:0] n_wide;
   logic signed [31:0] n_sat;

   assign accept   = req_valid & req_ready;
   assign clr_last = (clr_cnt_ff == ADDR_W'(qle_pkg::STORE_DEPTH - 1));
   assign last_rd  = (kind_ff == qle_pkg::REQ_UPDATE)
                     ? (rd_cnt_ff == CNT_W'(qle_pkg::NUM_ACTIONS))
                     : (rd_cnt_ff == CNT_W'(qle_pkg::NUM_ACTIONS - 1));
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qle_pkg::ST_CLEAR: if (clr_last) state_in = qle_pkg::ST_IDLE;
         qle_pkg::ST_IDLE:  if (accept) state_in = qle_pkg::ST_READ;
         qle_pkg::ST_READ:  if (last_rd) state_in = qle_pkg::ST_DRAIN;
         qle_pkg::ST_DRAIN: begin
            state_in = (kind_ff == qle_pkg::REQ_UPDATE) ? qle_pkg::ST_GAMMA : qle_pkg::ST_DONE;
         end
         qle_pkg::ST_GAMMA: state_in = qle_pkg::ST_DIFF;
         qle_pkg::ST_DIFF:  state_in = qle_pkg::ST_ALPHA;
         qle_pkg::ST_ALPHA: state_in = qle_pkg::ST_DONE;
         qle_pkg::ST_DONE:  if (out_free) state_in = qle_pkg::ST_IDLE;
         default:           state_in = qle_pkg::ST_CLEAR;
      endcase
   end

   // Read address for the current read slot
   always_comb begin
      rd_act = rd_cnt_ff[ACT_W-1:0];
      if (kind_ff == qle_pkg::REQ_UPDATE) begin
         rd_act = ACT_W'(rd_cnt_ff - CNT_W'(1));
      end
   end

   // Outputs and memory requests
   always_comb begin
      req_ready     = 1'b0;
      load          = 1'b0;
      clr_cnt_in    = clr_cnt_ff;
      rd_cnt_in     = rd_cnt_ff;
      ram_req.we    = 1'b0;
      ram_req.addr  = {cur_ff, act_ff[ACT_W-1:0]};
      ram_req.wdata = n_sat;
      case (state_ff)
         qle_pkg::ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = clr_cnt_ff;
            ram_req.wdata = '0;
            clr_cnt_in    = clr_cnt_ff + ADDR_W'(1);
         end
         qle_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_cnt_in = '0;
         end
         qle_pkg::ST_READ: begin
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            if (kind_ff == qle_pkg::REQ_QUERY) begin
               ram_req.addr = {cur_ff, rd_act};
            end else if (rd_cnt_ff != '0) begin
               ram_req.addr = {nxt_ff, rd_act};
            end
         end
         qle_pkg::ST_DONE: begin
            load       = out_free;
            ram_req.we = out_free & (kind_ff == qle_pkg::REQ_UPDATE);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qle_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         tag_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         tag_vld_ff   <= (state_ff == qle_pkg::ST_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);

   // Capture the request word
   always_ff @(posedge clock) begin
      rd_cnt_ff <= rd_cnt_in;
      tag_ff    <= rd_cnt_ff;
      if (accept) begin
         kind_ff <= req_type;
         cur_ff  <= {req_cell_x, req_cell_y, req_heading_bin};
         nxt_ff  <= {req_next_cell_x, req_next_cell_y, req_next_heading_bin};
         act_ff  <= req_action_index;
         rew_ff  <= req_reward_value;
         done_ff <= req_episode_done;
      end
   end

   // Sort returning read data: the current entry or one candidate for the max
   assign rd_val    = $signed(ram_rdata);
   assign data_is_q = (kind_ff == qle_pkg::REQ_UPDATE) && (tag_ff == '0);
   assign data_act  = (kind_ff == qle_pkg::REQ_UPDATE) ? ACT_W'(tag_ff - CNT_W'(1))
                                                       : tag_ff[ACT_W-1:0];

   always_ff @(posedge clock) begin
      if (tag_vld_ff) begin
         if (data_is_q) begin
            q_ff <= rd_val;
         end else if ((data_act == '0) || (rd_val > best_val_ff)) begin
            best_val_ff <= rd_val;
            best_act_ff <= data_act;
         end
      end
   end

   // Update arithmetic, at most one multiply per stage
   assign m_sel    = done_ff ? 32'sd0 : best_val_ff;
   assign gprod_in = $signed({1'b0, cfg.gamma}) * m_sel;
   assign diff_in  = 35'(rew_ff) + 35'($signed(gprod_ff[48:16])) - 35'(q_ff);
   assign aprod_in = $signed({1'b0, cfg.alpha}) * diff_ff;
   assign n_wide   = 36'(q_ff) + $signed(aprod_ff[51:16]);

   always_comb begin
      if (n_wide[35:31] == 5'b00000 || n_wide[35:31] == 5'b11111) begin
         n_sat = n_wide[31:0];
      end else if (n_wide[35]) begin
         n_sat = 32'sh8000_0000;
      end else begin
         n_sat = 32'sh7fff_ffff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == qle_pkg::ST_GAMMA) gprod_ff <= gprod_in;
      if (state_ff == qle_pkg::ST_DIFF)  diff_ff  <= diff_in;
      if (state_ff == qle_pkg::ST_ALPHA) aprod_ff <= aprod_in;
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (load) begin
         if (kind_ff == qle_pkg::REQ_UPDATE) begin
            rsp_act_ff <= act_ff;
            rsp_q_ff   <= n_sat;
         end else begin
            rsp_act_ff <= 2'(best_act_ff);
            rsp_q_ff   <= best_val_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_greedy_action = rsp_act_ff;
   assign rsp_q_result      = rsp_q_ff;

   assign status.clearing = (state_ff == qle_pkg::ST_CLEAR);

endmodule

`default_nettype wire

FILE: sv/tabular_q_learning_engine.sv
// Tabular Q-learning engine. A 32768-entry Q table (x, y, heading, action) sits in one
// single-port RAM with registered read data; after reset a clearing pass writes zero
// to every entry, one per cycle, during which req_ready stays low (register writes
// still go through). An update reads the current entry and the four next-state
// entries (five reads through the one port), runs three multiply/add stages and
// writes back. A query reads the four actions of the state. Both are paced by the
// memory port's one access per cycle, and one item is in flight at a time. The result
// sits in an output register, so the next item is taken while it waits.
`default_nettype none

module tabular_q_learning_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_type,
   input  wire logic [4:0]          req_cell_x,
   input  wire logic [4:0]          req_cell_y,
   input  wire logic [2:0]          req_heading_bin,
   input  wire logic [1:0]          req_action_index,
   input  wire logic signed [31:0]  req_reward_value,
   input  wire logic [4:0]          req_next_cell_x,
   input  wire logic [4:0]          req_next_cell_y,
   input  wire logic [2:0]          req_next_heading_bin,
   input  wire logic                req_episode_done,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_greedy_action,
   output logic signed [31:0]       rsp_q_result,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic      [31:0]         prdata,
   output logic                     pready
);

   qle_pkg::cfg_type     cfg;
   qle_pkg::ram_req_type ram_req;
   qle_pkg::status_type  status;
   logic [qle_pkg::Q_W-1:0] ram_rdata;

   // Register block
   qle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Q table
   qle_ram #(
      .WIDTH (qle_pkg::Q_W),
      .DEPTH (qle_pkg::STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   // Sequencer and datapath
   qle_core u_core (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_cell_x           (req_cell_x),
      .req_cell_y           (req_cell_y),
      .req_heading_bin      (req_heading_bin),
      .req_action_index     (req_action_index),
      .req_reward_value     (req_reward_value),
      .req_next_cell_x      (req_next_cell_x),
      .req_next_cell_y      (req_next_cell_y),
      .req_next_heading_bin (req_next_heading_bin),
      .req_episode_done     (req_episode_done),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_greedy_action    (rsp_greedy_action),
      .rsp_q_result         (rsp_q_result),
      .ram_req              (ram_req),
      .ram_rdata            (ram_rdata),
      .status               (status)
   );

   // One item in flight: an accepted word closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while an item is in flight");

   // No item enters while the table is being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req_ready)
      else $error("input ready during clearing pass");

   // A write-back always delivers its result word
   a_write_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (ram_req.we && !status.clearing) |=> rsp_valid)
      else $error("write-back without a result word");

endmodule

`default_nettype wire
